### sv/mm4_pkg.sv
`default_nettype none

package mm4_pkg;

  // Matrix geometry and number format
  localparam int unsigned DIM       = 4;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned TOTAL     = DIM * DIM;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned K_W    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned IDX_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned ACC_W  = PROD_W + K_W;

  // Sideband that travels with one product through the datapath
  typedef struct packed {
    logic vld;
    logic first;
    logic last_k;
    logic last_elem;
  } mac_tag_t;

endpackage

`default_nettype wire

### sv/mm4_mac.sv
`default_nettype none

module mm4_mac
  import mm4_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire logic signed [ELEM_W-1:0] a_i,
  input  wire logic signed [ELEM_W-1:0] b_i,
  input  wire mac_tag_t                 tag_i,
  output logic                          res_valid_o,
  output logic             [ELEM_W-1:0] res_o,
  output logic                          res_last_o
);

  localparam int unsigned HI_LSB = FRAC_BITS + ELEM_W - 1;

  logic signed [PROD_W-1:0] prod_q;
  mac_tag_t                 tag_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic                     done_q;
  logic                     last_q;
  logic [ACC_W-1-HI_LSB:0]  acc_hi;

  // Product stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  always_comb begin
    if (tag_q.first) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // Accumulate stage
  always_ff @(posedge clk_i) begin
    if (adv_i && tag_q.vld) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      done_q <= 1'b0;
      last_q <= 1'b0;
    end else if (adv_i) begin
      tag_q  <= tag_i;
      done_q <= tag_q.vld && tag_q.last_k;
      last_q <= tag_q.last_elem;
    end
  end

  // Drop the fraction bits (floor), clamp to the signed element range
  assign acc_hi = acc_q[ACC_W-1:HI_LSB];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      res_o = acc_q[HI_LSB:FRAC_BITS];
    end else if (acc_q[ACC_W-1]) begin
      res_o = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  assign res_valid_o = done_q;
  assign res_last_o  = last_q;

endmodule

`default_nettype wire

### sv/matrix4_multiply.sv
`default_nettype none

// Channel   Handshake                  Payload
// request   in_valid_i / in_stall_o    left_element_i, right_element_i
// result    out_valid_o / out_stall_i  product_element_o, last_element_o
//
// One request per cycle is written into the left and right memories. The
// last pair starts a pass of DIM*DIM*DIM = 64 products, DIM per result,
// with requests stalled, one product per cycle unless a result is stalled.
// After the last read come the product, accumulate and result registers.
// Reset clears only the load counter, sequencer, tags and valid/last flags.
// A stalled result freezes the pipeline; requests resume after the pass.

module matrix4_multiply
  import mm4_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ELEM_W-1:0] left_element_i,
  input  wire logic signed [ELEM_W-1:0] right_element_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [ELEM_W-1:0]      product_element_o,
  output logic                          last_element_o
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state_q, state_d;
  logic [IDX_W-1:0] load_cnt_q;
  logic [K_W-1:0]   row_q, row_d, col_q, col_d, k_q, k_d;

  logic [ELEM_W-1:0] left_mem  [TOTAL];
  logic [ELEM_W-1:0] right_mem [TOTAL];

  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  mac_tag_t                 tag_q, tag_d;
  logic [IDX_W-1:0]         a_addr, b_addr;

  logic              in_acc, issue, adv;
  logic              res_valid, res_last;
  logic [ELEM_W-1:0] res;
  logic              out_valid_q, out_last_q;
  logic [ELEM_W-1:0] out_q;

  // Freeze the datapath only while a finished result is held back
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == ST_CALC) && adv;

  // Element addresses: left row-major, right walks down a column
  assign a_addr = IDX_W'(32'(row_q) * DIM + 32'(k_q));
  assign b_addr = IDX_W'(32'(k_q) * DIM + 32'(col_q));

  // Request side: write the pair; operand reads advance with the datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_mem[load_cnt_q]  <= left_element_i;
      right_mem[load_cnt_q] <= right_element_i;
    end
    if (adv) begin
      a_rd_q <= left_mem[a_addr];
      b_rd_q <= right_mem[b_addr];
    end
  end

  // Product pass sequencer: k innermost, then column, then row
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    k_d     = k_q;
    tag_d   = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && (load_cnt_q == IDX_W'(TOTAL - 1))) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (issue) begin
          tag_d.vld       = 1'b1;
          tag_d.first     = (k_q == '0);
          tag_d.last_k    = (k_q == K_W'(DIM - 1));
          tag_d.last_elem = (row_q == K_W'(DIM - 1)) && (col_q == K_W'(DIM - 1));
          if (k_q == K_W'(DIM - 1)) begin
            k_d = '0;
            if (col_q == K_W'(DIM - 1)) begin
              col_d = '0;
              if (row_q == K_W'(DIM - 1)) begin
                row_d   = '0;
                state_d = ST_LOAD;
              end else begin
                row_d = row_q + K_W'(1);
              end
            end else begin
              col_d = col_q + K_W'(1);
            end
          end else begin
            k_d = k_q + K_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
      tag_q      <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      k_q     <= k_d;
      if (in_acc) begin
        if (load_cnt_q == IDX_W'(TOTAL - 1)) begin
          load_cnt_q <= '0;
        end else begin
          load_cnt_q <= load_cnt_q + IDX_W'(1);
        end
      end
      if (adv) begin
        tag_q <= tag_d;
      end
    end
  end

  mm4_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .a_i         (a_rd_q),
    .b_i         (b_rd_q),
    .tag_i       (tag_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_last_o  (res_last)
  );

  // Result register: load when empty or being taken, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
      out_last_q  <= res_last;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign product_element_o = out_q;
  assign last_element_o    = out_last_q;

endmodule

`default_nettype wire

### sv/mm4_checker.sv
`default_nettype none

module mm4_checker
  import mm4_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [ELEM_W-1:0] product_element_o,
  input wire logic              last_element_o
);

  logic             in_acc, out_acc;
  logic [IDX_W-1:0] in_cnt_q, out_cnt_q;
  logic [7:0]       pend_q, pend_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && (in_cnt_q == IDX_W'(TOTAL - 1))) begin
      pend_d = pend_d + 8'(TOTAL);
    end
    if (out_acc) begin
      pend_d = pend_d - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      pend_q    <= '0;
    end else begin
      pend_q <= pend_d;
      if (in_acc) begin
        in_cnt_q <= (in_cnt_q == IDX_W'(TOTAL - 1)) ? '0 : in_cnt_q + IDX_W'(1);
      end
      if (out_acc) begin
        out_cnt_q <= (out_cnt_q == IDX_W'(TOTAL - 1)) ? '0 : out_cnt_q + IDX_W'(1);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(product_element_o) && $stable(last_element_o))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 8'd0))
    else $error("result without a loaded matrix");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_element_o == (out_cnt_q == IDX_W'(TOTAL - 1))))
    else $error("last flag out of place");

endmodule

bind matrix4_multiply mm4_checker u_mm4_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .product_element_o (product_element_o),
  .last_element_o    (last_element_o)
);

`default_nettype wire

### tb/matrix_product_monitor.sv
`timescale 1ns / 1ps

module matrix_product_monitor
  import mm4_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [ELEM_W-1:0] left_element_i,
  input  wire logic [ELEM_W-1:0] right_element_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [ELEM_W-1:0] product_element_i,
  input  wire logic              last_element_i,
  output int                     mismatch_count_o,
  output int                     pending_o,
  output int                     taken_o
);

  // Four 64-bit products need 66 bits; keep some margin.
  localparam int SUM_W = 72;
  localparam logic signed [SUM_W-1:0] SAT_POS = 72'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_NEG = -72'sd2147483648;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              last;
  } product_t;

  logic signed [ELEM_W-1:0] a_mem [TOTAL];
  logic signed [ELEM_W-1:0] b_mem [TOTAL];
  int unsigned              pairs_loaded = 0;
  product_t                 product_q [$];
  product_t                 entry;
  int                       mismatches = 0;
  int                       taken = 0;

  // Row of A times column of B, exact sum, floor shift, saturate.
  function automatic logic [ELEM_W-1:0] dot_scaled(int row, int col);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] scaled;
    sum = '0;
    for (int k = 0; k < DIM; k++) begin
      sum = sum + a_mem[row*DIM + k] * b_mem[k*DIM + col];
    end
    scaled = sum >>> FRAC_BITS;
    if (scaled > SAT_POS) return 32'h7FFF_FFFF;
    if (scaled < SAT_NEG) return 32'h8000_0000;
    return scaled[ELEM_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_loaded = 0;
      product_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        a_mem[pairs_loaded] = left_element_i;
        b_mem[pairs_loaded] = right_element_i;
        pairs_loaded++;
        if (pairs_loaded == TOTAL) begin
          pairs_loaded = 0;
          for (int row = 0; row < DIM; row++) begin
            for (int col = 0; col < DIM; col++) begin
              entry.value = dot_scaled(row, col);
              entry.last  = (row == DIM - 1) && (col == DIM - 1);
              product_q.push_back(entry);
            end
          end
        end
      end
      if (out_valid_i && !out_stall_i) begin
        taken++;
        if (product_q.size() == 0) begin
          $display("%0t: unexpected product %h last %b", $time,
                   product_element_i, last_element_i);
          mismatches++;
        end else begin
          entry = product_q.pop_front();
          if (product_element_i !== entry.value) begin
            $display("%0t: product_element expected %h, got %h", $time,
                     entry.value, product_element_i);
            mismatches++;
          end
          if (last_element_i !== entry.last) begin
            $display("%0t: last_element expected %b, got %b", $time,
                     entry.last, last_element_i);
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= product_q.size();
    taken_o          <= taken;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mm4_pkg::*;

  typedef enum int {
    STYLE_FULL,
    STYLE_SMALL,
    STYLE_CORNER
  } elem_style_e;

  localparam logic [ELEM_W-1:0] ELEM_MAX     = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] ELEM_MIN     = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] ELEM_ONE     = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] ELEM_LSB     = 32'h0000_0001;
  localparam logic [ELEM_W-1:0] ELEM_NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [ELEM_W-1:0] ELEM_NEG_ONE = 32'hFFFF_0000;

  localparam int RANDOM_MATRICES = 12;
  localparam int DRAIN_PAUSE_AT  = 6;    // matrix index before which the sender drains
  localparam int HOLD_OFF_AT     = 40;   // results taken before the long hold-off
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int SETTLE_CYCLES   = 100;  // above one full product pass

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [ELEM_W-1:0] left_element_i  = '0;
  logic [ELEM_W-1:0] right_element_i = '0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [ELEM_W-1:0] product_element_o;
  logic              last_element_o;

  int mismatch_count;
  int pending_results;
  int results_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  matrix4_multiply dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .left_element_i    (left_element_i),
    .right_element_i   (right_element_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .product_element_o (product_element_o),
    .last_element_o    (last_element_o)
  );

  matrix_product_monitor product_mon (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .left_element_i    (left_element_i),
    .right_element_i   (right_element_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .product_element_i (product_element_o),
    .last_element_i    (last_element_o),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending_results),
    .taken_o           (results_taken)
  );

  // Mostly back-to-back requests, some short gaps, a few long ones.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Full-range words hit saturation, small ones (about +/-16.0) keep results
  // in range and exercise rounding, corners hit the field extremes.
  function automatic logic [ELEM_W-1:0] pick_element(elem_style_e style);
    case (style)
      STYLE_FULL:  return $urandom();
      STYLE_SMALL: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: begin
        case ($urandom_range(0, 6))
          0:       return ELEM_MAX;
          1:       return ELEM_MIN;
          2:       return '0;
          3:       return ELEM_LSB;
          4:       return ELEM_NEG_LSB;
          5:       return ELEM_NEG_ONE;
          default: return ELEM_ONE;
        endcase
      end
    endcase
  endfunction

  // Present one request and hold it until taken; drop valid only for a gap,
  // so a back-to-back request keeps valid high without a glitch.
  task automatic offer_pair(input logic [ELEM_W-1:0] a_elem,
                            input logic [ELEM_W-1:0] b_elem, input int gap);
    left_element_i  <= a_elem;
    right_element_i <= b_elem;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Request side: one directed matrix pair, then random ones.
  initial begin
    logic [ELEM_W-1:0] a_elem;
    logic [ELEM_W-1:0] b_elem;
    elem_style_e       style;
    bit                small_only;
    bit                burst;
    int                pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed matrix: all-max and all-min rows against max/min columns give
    // both saturations (min*min summed four times needs the full 66 bits);
    // single-LSB terms check the floor on small negative sums.
    for (int i = 0; i < TOTAL; i++) begin
      case (i)
        0:       begin a_elem = ELEM_MAX;     b_elem = ELEM_MAX;     end
        1:       begin a_elem = ELEM_MAX;     b_elem = ELEM_MIN;     end
        2:       begin a_elem = ELEM_MAX;     b_elem = ELEM_LSB;     end
        3:       begin a_elem = ELEM_MAX;     b_elem = ELEM_NEG_LSB; end
        4:       begin a_elem = ELEM_MIN;     b_elem = ELEM_MAX;     end
        5:       begin a_elem = ELEM_MIN;     b_elem = ELEM_MIN;     end
        6:       begin a_elem = ELEM_MIN;     b_elem = ELEM_ONE;     end
        7:       begin a_elem = ELEM_MIN;     b_elem = '0;           end
        8:       begin a_elem = ELEM_LSB;     b_elem = ELEM_MAX;     end
        9:       begin a_elem = ELEM_ONE;     b_elem = ELEM_MIN;     end
        10:      begin a_elem = '0;           b_elem = '0;           end
        11:      begin a_elem = '0;           b_elem = ELEM_NEG_ONE; end
        12:      begin a_elem = ELEM_NEG_LSB; b_elem = ELEM_MAX;     end
        13:      begin a_elem = '0;           b_elem = ELEM_MIN;     end
        14:      begin a_elem = ELEM_ONE;     b_elem = '0;           end
        default: begin a_elem = ELEM_NEG_ONE; b_elem = '0;           end
      endcase
      offer_pair(a_elem, b_elem, idle_gap());
    end

    for (int m = 0; m < RANDOM_MATRICES; m++) begin
      // Once, hold requests until every product has come back.
      if (m == DRAIN_PAUSE_AT) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_results != 0);
      end
      small_only = ($urandom_range(0, 9) < 4);
      burst      = ($urandom_range(0, 3) == 0);
      for (int e = 0; e < TOTAL; e++) begin
        pick  = $urandom_range(0, 9);
        style = (small_only || (pick >= 4 && pick < 8)) ? STYLE_SMALL :
                (pick < 4) ? STYLE_FULL : STYLE_CORNER;
        a_elem = pick_element(style);
        b_elem = pick_element(style);
        offer_pair(a_elem, b_elem, burst ? 0 : idle_gap());
      end
    end

    // Drain, let the block settle, then give the verdict.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Result side: alternate free and stalled runs of random length, with
  // one long hold-off while requests keep coming so the block backs up.
  initial begin
    bit held_off;
    bit run_stall;
    int run_left;
    int pick;

    held_off  = 1'b0;
    run_stall = 1'b1;
    run_left  = 0;
    forever begin
      @(posedge clk_i);
      if (!held_off && results_taken >= HOLD_OFF_AT) begin
        held_off  = 1'b1;
        run_stall = 1'b1;
        run_left  = HOLD_OFF_CYCLES;
      end else if (run_left == 0) begin
        run_stall = !run_stall;
        pick      = $urandom_range(0, 99);
        if (run_stall) begin
          run_left = (pick < 70) ? $urandom_range(1, 3) :
                     (pick < 92) ? $urandom_range(4, 12) : $urandom_range(20, 60);
        end else begin
          run_left = (pick < 80) ? $urandom_range(1, 12) : $urandom_range(50, 200);
        end
      end
      out_stall_i <= run_stall;
      run_left--;
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### sim.f
sv/mm4_pkg.sv
sv/mm4_mac.sv
sv/matrix4_multiply.sv
sv/mm4_checker.sv
tb/matrix_product_monitor.sv
tb/tb.sv
